// ===== sv/fmpd_pkg.sv =====
package fmpd_pkg;

    // Samples per output group.
    localparam int DECIMATION = 4;
    localparam int COUNT_W    = 7;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DC_OFFSET_I,
        CFG_DC_OFFSET_Q
    } t_cfg_index;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } t_fifo_entry;

    // Reciprocal divider: 2^23 / m with m in [256,511] gives a 16-bit quotient.
    localparam logic [8:0] DIV_INIT_REM      = 9'd128;
    localparam int         DIV_BITS_PER_STEP = 4;
    localparam int         DIV_STEPS         = 16 / DIV_BITS_PER_STEP;
    localparam int         DIV_CNT_W         = $clog2(DIV_STEPS);

    // Arctangent polynomial and folding constants.
    localparam logic [14:0]        RATIO_MAX  = 15'h7FFF;
    localparam logic [14:0]        ROUND_HALF = 15'h4000;
    localparam logic [11:0]        CORR_K     = 12'd2847;
    localparam logic signed [14:0] COEF_BASE  = 15'sd11039;
    localparam logic [15:0]        QUARTER    = 16'd16384;
    localparam logic [15:0]        HALF_TURN  = 16'd32768;

    // Divide by five: floor(n * 52429 / 2^18) is exact below 2^18.
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    // Divide by the group size through a rounded-up reciprocal.
    localparam int          MEAN_SHIFT = 29;
    localparam logic [29:0] MEAN_RECIP =
        30'(((1 << MEAN_SHIFT) + DECIMATION - 1) / DECIMATION);

endpackage

// ===== sv/fm_phase_discriminator_decimator.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_i_sample, i_q_sample, i_last_in_burst
// output    out        o_out_valid / i_out_stall o_luma_value
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// The front takes one sample per cycle, unless stalled, into a four-entry queue.
// The back handles one queued item at a time, popping the next only when idle; a zero
// conjugate product skips the divide and angle states, and a group's closing item adds
// the mean and emit states. Its sequencer, divider and staged multiplies set the rate.
// Reset is synchronous and active low; it clears offsets and all running state.
// The input stalls when the input stage holds a sample and the queue is full; a waiting result holds only the back.
module fm_phase_discriminator_decimator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fmpd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fmpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [7:0]                  i_i_sample,
    input  logic signed [7:0]                  i_q_sample,
    input  logic                               i_last_in_burst,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [15:0]                 o_luma_value
);
    import fmpd_pkg::*;

    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_fifo_entry w_push_data;
    t_fifo_entry w_pop_data;

    fmpd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_i_sample      (i_i_sample),
        .i_q_sample      (i_q_sample),
        .i_last_in_burst (i_last_in_burst),
        .i_fifo_full     (w_full),
        .o_fifo_push     (w_push),
        .o_fifo_data     (w_push_data)
    );

    fmpd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    fmpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (w_empty),
        .i_fifo_data  (w_pop_data),
        .o_fifo_pop   (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_luma_value (o_luma_value)
    );

endmodule

// ===== sv/fmpd_front.sv =====
module fmpd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fmpd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fmpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [7:0]                  i_i_sample,
    input  logic signed [7:0]                  i_q_sample,
    input  logic                               i_last_in_burst,
    input  logic                               i_fifo_full,
    output logic                               o_fifo_push,
    output fmpd_pkg::t_fifo_entry              o_fifo_data
);
    import fmpd_pkg::*;

    logic [7:0]         r_off_i;
    logic [7:0]         r_off_q;
    logic signed [8:0]  r_prev_i;
    logic signed [8:0]  r_prev_q;
    logic               r_s1_valid;
    logic signed [8:0]  r_s1_i;
    logic signed [8:0]  r_s1_q;
    logic signed [8:0]  r_s1_pi;
    logic signed [8:0]  r_s1_pq;
    logic               r_s1_last;

    logic               w_accept;
    logic signed [8:0]  w_si;
    logic signed [8:0]  w_sq;
    logic signed [17:0] w_ii;
    logic signed [17:0] w_qq;
    logic signed [17:0] w_qi;
    logic signed [17:0] w_iq;
    logic signed [18:0] w_re;
    logic signed [18:0] w_im;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] res;
        if (v > 19'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = 16'(v);
        end
        return res;
    endfunction

    // The stage stalls the input only while it holds a sample the queue cannot take.
    assign o_in_stall  = r_s1_valid && i_fifo_full;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_fifo_push = r_s1_valid && !i_fifo_full;

    // Remove the DC offsets.
    always_comb begin
        w_si = $signed({i_i_sample[7], i_i_sample}) - $signed({r_off_i[7], r_off_i});
        w_sq = $signed({i_q_sample[7], i_q_sample}) - $signed({r_off_q[7], r_off_q});
    end

    // Conjugate product with the previous sample, saturated to 16 bits.
    always_comb begin
        w_ii = r_s1_i * r_s1_pi;
        w_qq = r_s1_q * r_s1_pq;
        w_qi = r_s1_q * r_s1_pi;
        w_iq = r_s1_i * r_s1_pq;
        w_re = 19'(w_ii) + 19'(w_qq);
        w_im = 19'(w_qi) - 19'(w_iq);
        o_fifo_data.re   = sat16(w_re);
        o_fifo_data.im   = sat16(w_im);
        o_fifo_data.last = r_s1_last;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_i <= '0;
            r_off_q <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DC_OFFSET_I: r_off_i <= i_cfg_data;
                CFG_DC_OFFSET_Q: r_off_q <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage and previous-sample memory; a burst end clears the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_prev_i   <= '0;
            r_prev_q   <= '0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
            r_prev_i   <= i_last_in_burst ? 9'sd0 : w_si;
            r_prev_q   <= i_last_in_burst ? 9'sd0 : w_sq;
        end else if (o_fifo_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_i    <= w_si;
            r_s1_q    <= w_sq;
            r_s1_pi   <= r_prev_i;
            r_s1_pq   <= r_prev_q;
            r_s1_last <= i_last_in_burst;
        end
    end

`ifndef NO_ASSERTIONS
    a_burst_clears_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_in_burst) |=> (r_prev_i == 9'sd0 && r_prev_q == 9'sd0))
        else $error("previous sample not cleared after a burst end");
`endif

endmodule

// ===== sv/fmpd_fifo.sv =====
module fmpd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fmpd_pkg::t_fifo_entry i_push_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output fmpd_pkg::t_fifo_entry o_pop_data,
    output logic                  o_empty
);
    import fmpd_pkg::*;

    t_fifo_entry        r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full     = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== sv/fmpd_back.sv =====
module fmpd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fifo_empty,
    input  fmpd_pkg::t_fifo_entry i_fifo_data,
    output logic                  o_fifo_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_luma_value
);
    import fmpd_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FOLD,
        B_NORM,
        B_DIV,
        B_PROD,
        B_RATIO,
        B_CORR,
        B_COEF,
        B_BASE,
        B_ANGLE,
        B_AVG,
        B_DIV5,
        B_ACC,
        B_MEAN,
        B_EMIT
    } t_state;

    t_state                r_state;
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_y;
    logic                  r_last;
    logic [15:0]           r_num;
    logic [15:0]           r_den;
    logic                  r_swap;
    logic [3:0]            r_e;
    logic [8:0]            r_m;
    logic [8:0]            r_rem;
    logic [15:0]           r_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [31:0]           r_prod;
    logic [14:0]           r_ratio;
    logic [26:0]           r_t1;
    logic [13:0]           r_coef;
    logic [28:0]           r_t2;
    logic signed [15:0]    r_step;
    logic signed [15:0]    r_taps [4];
    logic [17:0]           r_avg_mag;
    logic                  r_avg_neg;
    logic [15:0]           r_q5;
    logic signed [23:0]    r_gsum;
    logic [COUNT_W-1:0]    r_gcount;
    logic [23:0]           r_mean_q;
    logic                  r_mean_neg;
    logic                  r_out_valid;
    logic signed [15:0]    r_luma;

    logic [15:0]           w_ax;
    logic [15:0]           w_ay;
    logic [3:0]            w_e;
    logic [15:0]           w_norm;
    logic [8:0]            w_rem;
    logic [15:0]           w_quo;
    logic [9:0]            w_rem2;
    logic [32:0]           w_rnd;
    logic [32:0]           w_rsum;
    logic [32:0]           w_rshift;
    logic [14:0]           w_ratio;
    logic signed [27:0]    w_neg;
    logic [14:0]           w_cbias;
    logic signed [27:0]    w_cs;
    logic signed [12:0]    w_corr;
    logic signed [14:0]    w_coef;
    logic [14:0]           w_abias;
    logic [29:0]           w_bsum;
    logic [14:0]           w_base;
    logic [15:0]           w_ang;
    logic [15:0]           w_turn;
    logic signed [18:0]    w_tsum;
    logic [17:0]           w_tmag;
    logic [33:0]           w_q5prod;
    logic signed [16:0]    w_avg;
    logic signed [23:0]    w_gsum;
    logic [COUNT_W-1:0]    w_gcount;
    logic [23:0]           w_gmag;
    logic [53:0]           w_mprod;
    logic signed [24:0]    w_mean;
    logic signed [15:0]    w_luma;
    logic                  w_out_free;

    assign o_fifo_pop   = (r_state == B_IDLE) && !i_fifo_empty;
    assign o_out_valid  = r_out_valid;
    assign o_luma_value = r_luma;
    assign w_out_free   = !r_out_valid || !i_out_stall;

    // Octant fold: magnitudes, then the smaller over the larger.
    always_comb begin
        w_ax = r_x[15] ? 16'(-r_x) : 16'(r_x);
        w_ay = r_y[15] ? 16'(-r_y) : 16'(r_y);
    end

    // Leading-one position and 9-bit mantissa of the divisor.
    always_comb begin
        w_e = '0;
        for (int k = 0; k < 16; k++) begin
            if (r_den[k]) begin
                w_e = 4'(k);
            end
        end
        w_norm = r_den << (4'd15 - w_e);
    end

    // Reciprocal divider, four quotient bits per cycle.
    always_comb begin
        w_rem  = r_rem;
        w_quo  = r_quo;
        w_rem2 = '0;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
            w_rem2 = {w_rem, 1'b0};
            if (w_rem2 >= {1'b0, r_m}) begin
                w_rem = 9'(w_rem2 - {1'b0, r_m});
                w_quo = {w_quo[14:0], 1'b1};
            end else begin
                w_rem = w_rem2[8:0];
                w_quo = {w_quo[14:0], 1'b0};
            end
        end
    end

    // Ratio: rounded shift of numerator times reciprocal, limited to Q15.
    always_comb begin
        w_rnd    = (33'd1 << r_e) >> 1;
        w_rsum   = {1'b0, r_prod} + w_rnd;
        w_rshift = w_rsum >> r_e;
        w_ratio  = (w_rshift > {18'd0, RATIO_MAX}) ? RATIO_MAX : w_rshift[14:0];
    end

    // Polynomial correction term with Q15 rounding; an exact half rounds down.
    always_comb begin
        w_neg   = -$signed({1'b0, r_t1});
        w_cbias = (w_neg[14:0] == ROUND_HALF) ? 15'd0 : ROUND_HALF;
        w_cs    = w_neg + $signed({13'd0, w_cbias});
        w_corr  = 13'(w_cs >>> 15);
        w_coef  = COEF_BASE + $signed({{2{w_corr[12]}}, w_corr});
    end

    // Base angle, octant and quadrant unfolding; the 16-bit wrap is free.
    always_comb begin
        w_abias = (r_t2[14:0] == ROUND_HALF) ? 15'd0 : ROUND_HALF;
        w_bsum  = {1'b0, r_t2} + {15'd0, w_abias};
        w_base  = w_bsum[29:15];
        w_ang   = r_swap ? 16'(QUARTER - {1'b0, w_base}) : {1'b0, w_base};
        case ({r_x[15], r_y[15]})
            2'b00:   w_turn = w_ang;
            2'b01:   w_turn = 16'(16'd0 - w_ang);
            2'b10:   w_turn = 16'(HALF_TURN - w_ang);
            2'b11:   w_turn = 16'(HALF_TURN + w_ang);
            default: w_turn = w_ang;
        endcase
    end

    // Five-tap box sum and divide by five.
    always_comb begin
        w_tsum = 19'(r_taps[0]) + 19'(r_taps[1]) + 19'(r_taps[2])
               + 19'(r_taps[3]) + 19'(r_step);
        w_tmag   = w_tsum[18] ? 18'(-w_tsum) : 18'(w_tsum);
        w_q5prod = 34'(r_avg_mag) * 34'(DIV5_RECIP);
        w_avg    = r_avg_neg ? -$signed({1'b0, r_q5}) : $signed({1'b0, r_q5});
    end

    // Group accumulation and group mean.
    always_comb begin
        w_gsum   = r_gsum + 24'(w_avg);
        w_gcount = r_gcount + 1'b1;
        w_gmag   = r_gsum[23] ? 24'(-r_gsum) : 24'(r_gsum);
        w_mprod  = 54'(w_gmag) * 54'(MEAN_RECIP);
        w_mean   = r_mean_neg ? -$signed({1'b0, r_mean_q}) : $signed({1'b0, r_mean_q});
        if (w_mean > 25'sd32767) begin
            w_luma = 16'sh7FFF;
        end else if (w_mean < -25'sd32768) begin
            w_luma = 16'sh8000;
        end else begin
            w_luma = 16'(w_mean);
        end
    end

    // Sequencer with its datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_gsum      <= '0;
            r_gcount    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_taps[k] <= '0;
            end
        end else begin
            // The emit state refills the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != B_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_fifo_empty) begin
                        r_x     <= i_fifo_data.re;
                        r_y     <= i_fifo_data.im;
                        r_last  <= i_fifo_data.last;
                        r_state <= B_FOLD;
                    end
                end
                B_FOLD: begin
                    r_swap  <= (w_ay > w_ax);
                    r_num   <= (w_ay > w_ax) ? w_ax : w_ay;
                    r_den   <= (w_ay > w_ax) ? w_ay : w_ax;
                    r_state <= B_NORM;
                end
                B_NORM: begin
                    r_e       <= w_e;
                    r_m       <= w_norm[15:7];
                    r_rem     <= DIV_INIT_REM;
                    r_quo     <= '0;
                    r_div_cnt <= '0;
                    if (r_den == '0) begin
                        r_step  <= '0;
                        r_state <= B_AVG;
                    end else begin
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem     <= w_rem;
                    r_quo     <= w_quo;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= B_PROD;
                    end
                end
                B_PROD: begin
                    r_prod  <= 32'(r_num) * 32'(r_quo);
                    r_state <= B_RATIO;
                end
                B_RATIO: begin
                    r_ratio <= w_ratio;
                    r_state <= B_CORR;
                end
                B_CORR: begin
                    r_t1    <= 27'(r_ratio) * 27'(CORR_K);
                    r_state <= B_COEF;
                end
                B_COEF: begin
                    r_coef  <= 14'(w_coef);
                    r_state <= B_BASE;
                end
                B_BASE: begin
                    r_t2    <= 29'(r_coef) * 29'(r_ratio);
                    r_state <= B_ANGLE;
                end
                B_ANGLE: begin
                    r_step  <= $signed(w_turn);
                    r_state <= B_AVG;
                end
                B_AVG: begin
                    r_avg_mag <= w_tmag;
                    r_avg_neg <= w_tsum[18];
                    r_taps[0] <= r_taps[1];
                    r_taps[1] <= r_taps[2];
                    r_taps[2] <= r_taps[3];
                    r_taps[3] <= r_step;
                    r_state   <= B_DIV5;
                end
                B_DIV5: begin
                    r_q5    <= 16'(w_q5prod >> DIV5_SHIFT);
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    if (w_gcount >= COUNT_W'(DECIMATION)) begin
                        r_gsum  <= w_gsum;
                        r_state <= B_MEAN;
                    end else if (r_last) begin
                        r_gsum   <= '0;
                        r_gcount <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_taps[k] <= '0;
                        end
                        r_state <= B_IDLE;
                    end else begin
                        r_gsum   <= w_gsum;
                        r_gcount <= w_gcount;
                        r_state  <= B_IDLE;
                    end
                end
                B_MEAN: begin
                    r_mean_q   <= 24'(w_mprod >> MEAN_SHIFT);
                    r_mean_neg <= r_gsum[23];
                    r_state    <= B_EMIT;
                end
                B_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_luma      <= w_luma;
                        r_gsum      <= '0;
                        r_gcount    <= '0;
                        if (r_last) begin
                            for (int k = 0; k < 4; k++) begin
                                r_taps[k] <= '0;
                            end
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_recip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_PROD) |-> (r_quo >= 16'd16416 && r_quo <= 16'd32768))
        else $error("reciprocal out of range");
    a_group_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (r_gcount < COUNT_W'(DECIMATION)))
        else $error("group count not wrapped");
`endif

endmodule
